// ===== design/tgrs_pkg.sv =====
package tgrs_pkg;

  localparam int CoordBits = 16;
  localparam int CellBits  = 6;
  localparam int ShiftBits = 4;
  localparam logic [ShiftBits-1:0] ShiftMin   = 4'd10;
  localparam logic [ShiftBits-1:0] ShiftMax   = 4'd15;
  localparam logic [ShiftBits-1:0] ShiftReset = 4'd10;

  // register address of cell_shift
  localparam logic [1:0] RegCellShift = 2'd0;

  // product of two 17 bit signed differences
  localparam int ProdBits = 2 * (CoordBits + 1);
  // magnitude of the adjusted dividend
  localparam int DvdBits  = ProdBits;

  // edge selector
  localparam logic EdgeFirst  = 1'b0;
  localparam logic EdgeSecond = 1'b1;

  // pass codes
  localparam logic PassUp   = 1'b0;
  localparam logic PassDown = 1'b1;

  typedef struct packed {
    logic [CoordBits-1:0] ax;
    logic [CoordBits-1:0] ay;
    logic [CoordBits-1:0] bx;
    logic [CoordBits-1:0] by;
    logic [CoordBits-1:0] cx;
    logic [CoordBits-1:0] cy;
  } in_t;

  typedef struct packed {
    logic [CellBits-1:0] row;
    logic [CellBits-1:0] col_first;
    logic [CellBits-1:0] col_last;
    logic                last;
  } out_t;

  typedef struct packed {
    logic load;
    logic init_up;
    logic init_down;
    logic mul;
    logic edge_sel;
    logic div_start;
    logic store;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic row_end;
    logic down_empty;
    logic out_free;
  } stat_t;

endpackage

// ===== design/tgrs_div.sv =====
module tgrs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [tgrs_pkg::DvdBits-1:0]      dividend,
  input  logic [tgrs_pkg::CoordBits-1:0]    divisor,
  output logic                              busy,
  output logic [tgrs_pkg::DvdBits-1:0]      quotient
);
  import tgrs_pkg::*;

  localparam int CntBits = $clog2(DvdBits + 1);

  logic [CoordBits-1:0] rem;
  logic [CoordBits-1:0] dsr;
  logic [CntBits-1:0]   cnt;
  logic [CoordBits:0]   trial;
  logic                 fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem, quotient[DvdBits-1]};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= CntBits'(DvdBits);
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? CoordBits'(trial - {1'b0, dsr}) : trial[CoordBits-1:0];
      quotient <= {quotient[DvdBits-2:0], fits};
      cnt      <= cnt - 1'b1;
      if (cnt == CntBits'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== design/tgrs_dp.sv =====
module tgrs_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  tgrs_pkg::cmd_t                 cmd,
  output tgrs_pkg::stat_t                stat,
  input  tgrs_pkg::in_t                  in_data,
  input  logic [tgrs_pkg::ShiftBits-1:0] cell_shift,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tgrs_pkg::out_t                 out_data
);
  import tgrs_pkg::*;

  localparam int YBits = CoordBits + CellBits;

  logic [CoordBits-1:0] xa, ya, xb, yb, xc, yc;
  logic [CoordBits-1:0] s_xa, s_ya, s_xb, s_yb, s_xc, s_yc, t;
  logic [ShiftBits-1:0] sh;
  logic [CellBits-1:0]  iya, iyb, iyc;
  logic [CellBits-1:0]  row, prev0, prev1, e0, e1;
  logic                 pass;

  logic [CoordBits-1:0] x0, y0, x1, y1, ylo, yhi, yclamp;
  logic [CellBits:0]    row_p;
  logic [YBits-1:0]     ybnd;
  logic signed [CoordBits:0] dx, dy, dn;

  logic signed [ProdBits-1:0] prod;
  logic signed [CoordBits:0]  den;
  logic [CoordBits-1:0]       ex0, ex1;
  logic                       flat, negq;
  logic signed [ProdBits:0]   dvd;
  logic [DvdBits-1:0]         dmag, quo;
  logic [CoordBits-1:0]       dsr;
  logic                       div_busy;
  logic signed [DvdBits+1:0]  qv, xs;
  logic [DvdBits+1:0]         xsh;
  logic [CellBits-1:0]        edge_col;
  logic [CellBits-1:0]        lo, hi, m0, m1, n0, n1;

  // clamp of the configured shift
  always_comb begin
    sh = cell_shift;
    if (cell_shift < ShiftMin) sh = ShiftMin;
    if (cell_shift > ShiftMax) sh = ShiftMax;
  end

  // sort by y, swapping only on strictly less
  always_comb begin
    t    = '0;
    s_xa = in_data.ax; s_ya = in_data.ay;
    s_xb = in_data.bx; s_yb = in_data.by;
    s_xc = in_data.cx; s_yc = in_data.cy;
    if (s_yb < s_ya) begin
      t = s_xa; s_xa = s_xb; s_xb = t; t = s_ya; s_ya = s_yb; s_yb = t;
    end
    if (s_yc < s_ya) begin
      t = s_xa; s_xa = s_xc; s_xc = t; t = s_ya; s_ya = s_yc; s_yc = t;
    end
    if (s_yc < s_yb) begin
      t = s_xb; s_xb = s_xc; s_xc = t; t = s_yb; s_yb = s_yc; s_yc = t;
    end
  end

  assign iya = CellBits'(ya >> sh);
  assign iyb = CellBits'(yb >> sh);
  assign iyc = CellBits'(yc >> sh);

  // edge endpoints for the current pass
  always_comb begin
    if (pass == PassUp) begin
      x0 = xa; y0 = ya;
      x1 = (cmd.edge_sel == EdgeFirst) ? xb : xc;
      y1 = (cmd.edge_sel == EdgeFirst) ? yb : yc;
    end else begin
      x0 = xc; y0 = yc;
      x1 = (cmd.edge_sel == EdgeFirst) ? xa : xb;
      y1 = (cmd.edge_sel == EdgeFirst) ? ya : yb;
    end
    ylo   = (y0 < y1) ? y0 : y1;
    yhi   = (y0 < y1) ? y1 : y0;
    row_p = (pass == PassUp) ? ({1'b0, row} + 1'b1) : {1'b0, row};
    ybnd  = YBits'(row_p) << sh;
    if (ybnd < YBits'(ylo)) begin
      yclamp = ylo;
    end else if (ybnd > YBits'(yhi)) begin
      yclamp = yhi;
    end else begin
      yclamp = ybnd[CoordBits-1:0];
    end
    dx = $signed({1'b0, x1}) - $signed({1'b0, x0});
    dy = $signed({1'b0, yclamp}) - $signed({1'b0, y0});
    dn = $signed({1'b0, y1}) - $signed({1'b0, y0});
  end

  // floor division written as a truncating division of an adjusted dividend
  always_comb begin
    if (prod[ProdBits-1]) begin
      dvd = -(ProdBits+1)'(prod) + (ProdBits+1)'(den) - (ProdBits+1)'(1);
    end else begin
      dvd = (ProdBits+1)'(prod);
    end
    dmag = dvd[ProdBits] ? DvdBits'(-dvd) : DvdBits'(dvd);
    dsr  = den[CoordBits] ? CoordBits'(-den) : CoordBits'(den);
  end

  tgrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dmag),
    .divisor  (dsr),
    .busy     (div_busy),
    .quotient (quo)
  );

  // edge x to cell
  always_comb begin
    qv  = $signed({2'b00, quo});
    xs  = $signed((DvdBits+2)'(ex0)) + (negq ? -qv : qv);
    xsh = xs[DvdBits+1] ? '0 : ($unsigned(xs) >> sh);
    if (flat) begin
      edge_col = CellBits'(ex1 >> sh);
    end else if (xsh > (DvdBits+2)'({CellBits{1'b1}})) begin
      edge_col = {CellBits{1'b1}};
    end else begin
      edge_col = xsh[CellBits-1:0];
    end
  end

  // span bounds over both boundaries
  always_comb begin
    m0 = (e0 < e1) ? e0 : e1;
    m1 = (prev0 < prev1) ? prev0 : prev1;
    n0 = (e0 > e1) ? e0 : e1;
    n1 = (prev0 > prev1) ? prev0 : prev1;
    lo = (m0 < m1) ? m0 : m1;
    hi = (n0 > n1) ? n0 : n1;
  end

  always_comb begin
    stat.div_busy   = div_busy;
    stat.row_end    = (pass == PassUp) ? (row == iyb) : (row == iyb + 1'b1);
    stat.down_empty = (iyc == iyb);
    stat.out_free   = !out_valid || out_ready;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xa <= s_xa; ya <= s_ya;
      xb <= s_xb; yb <= s_yb;
      xc <= s_xc; yc <= s_yc;
    end
    if (cmd.init_up) begin
      prev0 <= CellBits'(xa >> sh);
      prev1 <= CellBits'(xa >> sh);
      row   <= iya;
    end
    if (cmd.init_down) begin
      prev0 <= CellBits'(xc >> sh);
      prev1 <= CellBits'(xc >> sh);
      row   <= iyc;
    end
    if (cmd.mul) begin
      prod <= ProdBits'(dx) * ProdBits'(dy);
      den  <= dn;
      ex0  <= x0;
      ex1  <= x1;
      flat <= (y1 == y0);
    end
    if (cmd.div_start) begin
      negq <= dvd[ProdBits] ^ den[CoordBits] ^ prod[ProdBits-1];
    end
    if (cmd.store) begin
      if (cmd.edge_sel == EdgeFirst) begin
        e0 <= edge_col;
      end else begin
        e1 <= edge_col;
      end
    end
    if (cmd.emit) begin
      out_data.row       <= row;
      out_data.col_first <= lo;
      out_data.col_last  <= hi;
      out_data.last      <= stat.row_end && (pass == PassDown || stat.down_empty);
      prev0 <= e0;
      prev1 <= e1;
      row   <= (pass == PassUp) ? row + 1'b1 : row - 1'b1;
    end
  end

  // pass flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pass      <= PassUp;
      out_valid <= 1'b0;
    end else begin
      if (cmd.init_up) pass <= PassUp;
      if (cmd.init_down) pass <= PassDown;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/tgrs_ctrl.sv =====
module tgrs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tgrs_pkg::stat_t stat,
  output tgrs_pkg::cmd_t  cmd
);
  import tgrs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT_UP, S_INIT_DOWN, S_MUL, S_DIV_GO, S_DIV_WAIT, S_STORE, S_EMIT
  } state_t;

  state_t state;
  logic   sel;
  logic   down_pass;

  assign in_ready = (state == S_IDLE);

  // commands decoded from state
  always_comb begin
    cmd           = '0;
    cmd.edge_sel  = sel;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.init_up   = (state == S_INIT_UP);
    cmd.init_down = (state == S_INIT_DOWN);
    cmd.mul       = (state == S_MUL);
    cmd.div_start = (state == S_DIV_GO);
    cmd.store     = (state == S_STORE);
    cmd.emit      = (state == S_EMIT) && stat.out_free;
  end

  // the row just finished ends the triangle
  function automatic logic last_span();
    return stat.down_empty || down_pass;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      down_pass <= 1'b0;
    end else if (state == S_INIT_UP) begin
      down_pass <= 1'b0;
    end else if (state == S_INIT_DOWN) begin
      down_pass <= 1'b1;
    end
  end

  // sequencer: each edge of a row in turn, then its span
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= EdgeFirst;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_INIT_UP;
        end
        S_INIT_UP, S_INIT_DOWN: begin
          sel   <= EdgeFirst;
          state <= S_MUL;
        end
        S_MUL: state <= S_DIV_GO;
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!stat.div_busy) state <= S_STORE;
        end
        S_STORE: begin
          if (sel == EdgeFirst) begin
            sel   <= EdgeSecond;
            state <= S_MUL;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (stat.out_free) begin
            sel <= EdgeFirst;
            priority if (!stat.row_end) begin
              state <= S_MUL;
            end else if (cmd.emit && !last_span()) begin
              state <= S_INIT_DOWN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/triangle_grid_row_spans.sv =====
// channel  | direction | handshake              | payload
// in       | input     | in_valid / in_ready    | in_data  (three vertices)
// out      | output    | out_valid / out_ready  | out_data (one row span)
// cfg      | input     | APB psel/penable/pwrite| cell_shift at address 0
//
// one triangle at a time: a set-up state at the start of each pass, then for
// each covered row an evaluation of each of its edges (multiply, divider start,
// wait on the 34 step serial divider, store) followed by the emit of its span;
// up to 64 spans per triangle
// reset is synchronous and active high; cell_shift returns to 10
// a full output register stalls the sequencer until the span is taken
module triangle_grid_row_spans (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tgrs_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tgrs_pkg::out_t                 out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [1:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import tgrs_pkg::*;

  logic [ShiftBits-1:0] cell_shift;
  cmd_t                 cmd;
  stat_t                stat;

  // configuration register, single word at address 0
  assign pready = 1'b1;
  assign prdata = {{(32-ShiftBits){1'b0}}, cell_shift};

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_shift <= ShiftReset;
    end else if (psel && penable && pwrite && (paddr == RegCellShift)) begin
      cell_shift <= pwdata[ShiftBits-1:0];
    end
  end

  tgrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tgrs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (in_data),
    .cell_shift (cell_shift),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== design/tgrs_check.sv =====
module tgrs_check (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tgrs_pkg::out_t out_data
);
  import tgrs_pkg::*;

  // output held until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output dropped before transfer");

  // a triangle occupies the block once taken
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // spans still to come keep the input closed
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input opened before last span");

  // span is ordered
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.col_first <= out_data.col_last)
    else $error("span first column beyond last");

  // nothing pending after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind triangle_grid_row_spans tgrs_check u_tgrs_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
